@@ src/rwvh_pkg.sv @@
// ----------------------------------------------------------------------------
// rwvh_pkg
// Shared types, codes and sizes for the lattice walk visit histogram core.
// ----------------------------------------------------------------------------
package rwvh_pkg;

    // Field and register widths
    localparam int DIM_W      = 10;
    localparam int POS_W      = 9;
    localparam int LEVEL_W    = 8;
    localparam int PEAK_OUT_W = 16;
    localparam int KIND_W     = 2;
    localparam int DIR_W      = 2;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 48;
    localparam int CFG_IDX_W  = 2;

    // Restart generation tag kept beside every cell count
    localparam int EPOCH_BITS = 8;

    // Parameter defaults
    localparam int MAX_COLS_DEF   = 512;
    localparam int MAX_ROWS_DEF   = 512;
    localparam int COUNT_BITS_DEF = 16;

    // Register reset values
    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = 10'd512;
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = 10'd512;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_STEP    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

    // Step directions
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd2;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE   = 2'd2;

    // Edge modes
    localparam logic EDGE_WRAP  = 1'b0;
    localparam logic EDGE_CLAMP = 1'b1;

endpackage

@@ src/random_walk_visit_histogram_core.sv @@
// ----------------------------------------------------------------------------
// random_walk_visit_histogram_core
// Lattice random walk keeping a visit-count grid in one synchronous memory.
//
// Input items arrive on s_axis (kind in tuser, direction and read cell in
// tdata); each gives one result item on m_axis with the walker position,
// the scaled level of a read cell and the peak count. Registers are written
// through cfg_we / cfg_index / cfg_wdata; the user must write them only while
// the core is idle, which the core does not enforce. A step is a memory read,
// then the increment is written back. A read is a memory read, scale by 255,
// then a bit-per-cycle divide by the peak. A restart or an unused kind gives
// its result from the idle state. Each cell carries a restart tag, so a
// restart is a tag bump; every 256th restart and the time after reset run a
// clearing pass over all MAX_ROWS*MAX_COLS cells with s_axis_tready low.
// A result waits in an output register; the next item is taken only once
// that register is free or drains in the same cycle, so a stalled receiver
// holds the input side off after one pending result.
// ----------------------------------------------------------------------------
module random_walk_visit_histogram_core #(
    parameter int MAX_COLS   = rwvh_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS   = rwvh_pkg::MAX_ROWS_DEF,
    parameter int COUNT_BITS = rwvh_pkg::COUNT_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // direction[1:0], read_col[10:2], read_row[19:11], zero fill
    input  logic [rwvh_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // kind[1:0]
    input  logic [rwvh_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // walker_x[8:0], walker_y[17:9], pixel_level[25:18], peak_visits[41:26]
    output logic [rwvh_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [rwvh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rwvh_pkg::DIM_W-1:0]          cfg_wdata
);

    localparam int DIM_W   = rwvh_pkg::DIM_W;
    localparam int POS_W   = rwvh_pkg::POS_W;
    localparam int LW      = rwvh_pkg::LEVEL_W;
    localparam int PEAK_W  = rwvh_pkg::PEAK_OUT_W;
    localparam int EB      = rwvh_pkg::EPOCH_BITS;
    localparam int MW      = EB + COUNT_BITS;
    localparam int DEPTH   = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int COL_LIM = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;
    localparam int ROW_LIM = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
    localparam logic [DIM_W-1:0] COL_LIM_V = DIM_W'(COL_LIM);
    localparam logic [DIM_W-1:0] ROW_LIM_V = DIM_W'(ROW_LIM);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_STEP  = 3'd2;
    localparam logic [2:0] ST_RDMEM = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;

    logic [MW-1:0] mem [DEPTH];
    logic [MW-1:0] mem_rdata_reg;
    logic          mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic          mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [DIM_W-1:0]      grid_width_reg;
    logic [DIM_W-1:0]      grid_height_reg;
    logic                  edge_mode_reg;
    logic [DIM_W-1:0]      walker_col_reg;
    logic [DIM_W-1:0]      walker_col_next;
    logic [DIM_W-1:0]      walker_row_reg;
    logic [DIM_W-1:0]      walker_row_next;
    logic [COUNT_BITS-1:0] peak_reg;
    logic [COUNT_BITS-1:0] peak_next;
    logic [EB-1:0]         epoch_reg;
    logic [EB-1:0]         epoch_next;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic [ADDR_W-1:0]     clr_addr_next;
    logic [ADDR_W-1:0]     addr_reg;
    logic [ADDR_W-1:0]     addr_next;
    logic [rwvh_pkg::DIR_W-1:0] dir_reg;
    logic [rwvh_pkg::DIR_W-1:0] dir_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [rwvh_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [rwvh_pkg::OUT_DATA_W-1:0] out_data_next;

    logic [DIM_W-1:0]      w_use;
    logic [DIM_W-1:0]      h_use;
    logic [DIM_W-1:0]      col_c;
    logic [DIM_W-1:0]      row_c;
    logic                  in_fire;
    logic [rwvh_pkg::KIND_W-1:0] in_kind;
    logic [rwvh_pkg::DIR_W-1:0]  in_dir;
    logic [POS_W-1:0]      in_col;
    logic [POS_W-1:0]      in_row;
    logic                  read_ok;
    logic [COUNT_BITS-1:0] cell_count;
    logic [COUNT_BITS-1:0] step_inc;
    logic                  load;
    logic [DIM_W-1:0]      res_col;
    logic [DIM_W-1:0]      res_row;
    logic [COUNT_BITS-1:0] res_peak;
    logic [LW-1:0]         res_level;

    logic                       div_start;
    logic [COUNT_BITS+LW-1:0]   div_num;
    logic                       div_done;
    logic [LW-1:0]              div_q;

    rwvh_divider #(
        .COUNT_BITS(COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numerator(div_num),
        .divisor  (peak_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Dimensions in use and walker clamped into them
    always_comb
    begin
        if (grid_width_reg == '0)
            w_use = DIM_W'(1);
        else
            w_use = (grid_width_reg > COL_LIM_V) ? COL_LIM_V : grid_width_reg;
        if (grid_height_reg == '0)
            h_use = DIM_W'(1);
        else
            h_use = (grid_height_reg > ROW_LIM_V) ? ROW_LIM_V : grid_height_reg;
        col_c = (walker_col_reg >= w_use) ? w_use - DIM_W'(1) : walker_col_reg;
        row_c = (walker_row_reg >= h_use) ? h_use - DIM_W'(1) : walker_row_reg;
    end

    assign in_kind = s_axis_tuser;
    assign in_dir  = s_axis_tdata[1:0];
    assign in_col  = s_axis_tdata[10:2];
    assign in_row  = s_axis_tdata[19:11];
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign read_ok = ({1'b0, in_col} < w_use) && ({1'b0, in_row} < h_use)
                     && (peak_reg != '0);

    // Entry with a stale tag counts as zero
    assign cell_count = (mem_rdata_reg[MW-1:COUNT_BITS] == epoch_reg)
                        ? mem_rdata_reg[COUNT_BITS-1:0] : '0;
    assign step_inc   = (cell_count == COUNT_MAX) ? cell_count
                                                  : cell_count + COUNT_BITS'(1);
    assign div_num    = {cell_count, LW'(0)} - (COUNT_BITS+LW)'(cell_count);

    always_comb
    begin
        state_next      = state_reg;
        walker_col_next = walker_col_reg;
        walker_row_next = walker_row_reg;
        peak_next       = peak_reg;
        epoch_next      = epoch_reg;
        clr_addr_next   = clr_addr_reg;
        addr_next       = addr_reg;
        dir_next        = dir_reg;
        mem_re          = 1'b0;
        mem_raddr       = addr_reg;
        mem_we          = 1'b0;
        mem_waddr       = addr_reg;
        mem_wdata       = {epoch_reg, step_inc};
        div_start       = 1'b0;
        load            = 1'b0;
        res_level       = '0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    priority if (in_kind == rwvh_pkg::KIND_STEP)
                    begin
                        walker_col_next = col_c;
                        walker_row_next = row_c;
                        addr_next  = ADDR_W'(32'(row_c) * MAX_COLS + 32'(col_c));
                        mem_re     = 1'b1;
                        mem_raddr  = addr_next;
                        dir_next   = in_dir;
                        state_next = ST_STEP;
                    end
                    else if (in_kind == rwvh_pkg::KIND_READ && read_ok)
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = ADDR_W'(32'(in_row) * MAX_COLS + 32'(in_col));
                        state_next = ST_RDMEM;
                    end
                    else if (in_kind == rwvh_pkg::KIND_RESTART)
                    begin
                        walker_col_next = w_use >> 1;
                        walker_row_next = h_use >> 1;
                        peak_next       = '0;
                        load            = 1'b1;
                        if (epoch_reg == '1)
                        begin
                            epoch_next = '0;
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            epoch_next = epoch_reg + EB'(1);
                        end
                    end
                    else
                    begin
                        load = 1'b1;
                    end
                end
            end
            ST_STEP:
            begin
                mem_we    = 1'b1;
                peak_next = (step_inc > peak_reg) ? step_inc : peak_reg;
                unique case (dir_reg)
                    rwvh_pkg::DIR_RIGHT:
                        if (edge_mode_reg == rwvh_pkg::EDGE_CLAMP)
                            walker_col_next = (walker_col_reg + DIM_W'(1) < w_use)
                                ? walker_col_reg + DIM_W'(1) : walker_col_reg;
                        else
                            walker_col_next = (walker_col_reg + DIM_W'(1) == w_use)
                                ? '0 : walker_col_reg + DIM_W'(1);
                    rwvh_pkg::DIR_LEFT:
                        if (walker_col_reg != '0)
                            walker_col_next = walker_col_reg - DIM_W'(1);
                        else if (edge_mode_reg == rwvh_pkg::EDGE_WRAP)
                            walker_col_next = w_use - DIM_W'(1);
                    rwvh_pkg::DIR_UP:
                        if (edge_mode_reg == rwvh_pkg::EDGE_CLAMP)
                            walker_row_next = (walker_row_reg + DIM_W'(1) < h_use)
                                ? walker_row_reg + DIM_W'(1) : walker_row_reg;
                        else
                            walker_row_next = (walker_row_reg + DIM_W'(1) == h_use)
                                ? '0 : walker_row_reg + DIM_W'(1);
                    rwvh_pkg::DIR_DOWN:
                        if (walker_row_reg != '0)
                            walker_row_next = walker_row_reg - DIM_W'(1);
                        else if (edge_mode_reg == rwvh_pkg::EDGE_WRAP)
                            walker_row_next = h_use - DIM_W'(1);
                    default: ;
                endcase
                load       = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RDMEM:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_level  = div_q;
                    load       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res_col  = walker_col_next;
        res_row  = walker_row_next;
        res_peak = peak_next;
        out_data_next = {6'd0, PEAK_W'(res_peak), res_level,
                         res_row[POS_W-1:0], res_col[POS_W-1:0]};
        if (load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && !m_axis_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            grid_width_reg  <= rwvh_pkg::GRID_WIDTH_RST;
            grid_height_reg <= rwvh_pkg::GRID_HEIGHT_RST;
            edge_mode_reg   <= rwvh_pkg::EDGE_WRAP;
            walker_col_reg  <= '0;
            walker_row_reg  <= '0;
            peak_reg        <= '0;
            epoch_reg       <= '0;
            clr_addr_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            walker_col_reg <= walker_col_next;
            walker_row_reg <= walker_row_next;
            peak_reg       <= peak_next;
            epoch_reg      <= epoch_next;
            clr_addr_reg   <= clr_addr_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    rwvh_pkg::CFG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata;
                    rwvh_pkg::CFG_GRID_HEIGHT: grid_height_reg <= cfg_wdata;
                    rwvh_pkg::CFG_EDGE_MODE:   edge_mode_reg   <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        dir_reg  <= dir_next;
        if (load)
            out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_rdata_reg <= mem[mem_raddr];
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_axis_tready)
        else $error("input accepted during clearing pass");

    a_peak_covers_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (peak_reg >= $past(step_inc)))
        else $error("peak below a written cell count");

    a_walker_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STEP) |=> (walker_col_reg < w_use && walker_row_reg < h_use))
        else $error("walker left the grid after a step");

    a_slot_free_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> (!out_valid_reg || m_axis_tready))
        else $error("item accepted while a result is stuck");

endmodule

@@ src/rwvh_divider.sv @@
// ----------------------------------------------------------------------------
// rwvh_divider
// Restoring divider, one quotient bit per cycle, for count * 255 / peak
// where the count never exceeds the peak, so the quotient fits LEVEL_W bits.
// ----------------------------------------------------------------------------
module rwvh_divider #(
    parameter int COUNT_BITS = rwvh_pkg::COUNT_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [COUNT_BITS+rwvh_pkg::LEVEL_W-1:0] numerator,
    input  logic [COUNT_BITS-1:0]                 divisor,
    output logic                                  done,
    output logic [rwvh_pkg::LEVEL_W-1:0]          quotient
);

    localparam int LW    = rwvh_pkg::LEVEL_W;
    localparam int CNT_W = $clog2(LW);

    logic                  busy_reg;
    logic                  busy_next;
    logic                  done_reg;
    logic                  done_next;
    logic [CNT_W-1:0]      cnt_reg;
    logic [CNT_W-1:0]      cnt_next;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [COUNT_BITS-1:0] rem_next;
    logic [LW-1:0]         num_lo_reg;
    logic [LW-1:0]         num_lo_next;
    logic [LW-1:0]         q_reg;
    logic [LW-1:0]         q_next;
    logic [COUNT_BITS-1:0] div_reg;
    logic [COUNT_BITS-1:0] div_next;
    logic [COUNT_BITS:0]   trial;
    logic                  fits;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        num_lo_next = num_lo_reg;
        q_next      = q_reg;
        div_next    = div_reg;
        trial       = {rem_reg, num_lo_reg[LW-1]};
        fits        = (trial >= {1'b0, div_reg});
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = '0;
            rem_next    = numerator[COUNT_BITS+LW-1:LW];
            num_lo_next = numerator[LW-1:0];
            div_next    = divisor;
            q_next      = '0;
        end
        else if (busy_reg)
        begin
            rem_next    = fits ? COUNT_BITS'(trial - {1'b0, div_reg})
                               : trial[COUNT_BITS-1:0];
            q_next      = {q_reg[LW-2:0], fits};
            num_lo_next = {num_lo_reg[LW-2:0], 1'b0};
            cnt_next    = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(LW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        num_lo_reg <= num_lo_next;
        q_reg      <= q_next;
        div_reg    <= div_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
